FILE: rtl/shp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_pkg
// Shared widths, register codes, types and the per-pixel sharpen kernel for
// the 3x3 saturating sharpen filter.
// ----------------------------------------------------------------------------
package shp_pkg;

    localparam int MAX_LINE_WIDTH = 512;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int LW_W     = 10;
    localparam int FH_W     = 12;
    localparam int ROW_W    = 12;
    localparam int PXCOL_W  = 9;
    localparam int COL_W    = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WD_CLOG  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int WD_W     = (WD_CLOG > LW_W) ? WD_CLOG : LW_W;

    localparam int MIN_DIM  = 3;
    localparam int CH_MAX   = 255;
    localparam int NSUM_W   = CH_W + 3;
    localparam int GAIN_W   = CH_W + 4;

    localparam int LW_RESET = 480;
    localparam int FH_RESET = 360;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FH_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_LINE_WIDTH   = t_cfg_idx'(0);
    localparam t_cfg_idx REG_FRAME_HEIGHT = t_cfg_idx'(1);

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;

    // pixel waiting on its line store read
    typedef struct packed {
        t_pix       px;
        t_col       col;
        t_row       row;
        logic       edge_px;
        logic [2:0] emit;
    } t_stage;

    typedef struct packed {
        logic [CH_W-1:0]    out_red;
        logic [CH_W-1:0]    out_green;
        logic [CH_W-1:0]    out_blue;
        logic [PXCOL_W-1:0] pixel_column;
        logic [ROW_W-1:0]   pixel_row;
        logic               last_of_run;
    } t_result;

    // w[col*3+row], col left..right, row top..bottom
    function automatic t_pix sharpen(input logic [8:0][PIX_W-1:0] w);
        t_pix              res;
        logic [NSUM_W-1:0] nsum;
        logic [GAIN_W-1:0] gain;
        logic [GAIN_W-1:0] diff;
        logic [CH_W-1:0]   ctr;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            nsum = '0;
            for (int i = 0; i < 9; i++) begin
                if (i != 4) begin
                    nsum = nsum + NSUM_W'(w[i][ch*CH_W +: CH_W]);
                end
            end
            ctr  = w[4][ch*CH_W +: CH_W];
            gain = (GAIN_W'(ctr) << 3) + GAIN_W'(ctr);
            diff = gain - GAIN_W'(nsum);
            if (GAIN_W'(nsum) >= gain) begin
                res[ch*CH_W +: CH_W] = '0;
            end else if (diff > GAIN_W'(CH_MAX)) begin
                res[ch*CH_W +: CH_W] = CH_W'(CH_MAX);
            end else begin
                res[ch*CH_W +: CH_W] = diff[CH_W-1:0];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/shp_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_cfg_if
// Register write channel: register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface shp_cfg_if import shp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/shp_pix_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_pix_in_if
// Incoming RGB pixel channel with valid/ready.
// ----------------------------------------------------------------------------
interface shp_pix_in_if import shp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/shp_pix_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_pix_out_if
// Sharpened pixel channel with coordinates and run marker, valid/ready.
// ----------------------------------------------------------------------------
interface shp_pix_out_if import shp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [PXCOL_W-1:0] pixel_column;
    logic [ROW_W-1:0]   pixel_row;
    logic               last_of_run;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output pixel_column, output pixel_row, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input pixel_column, input pixel_row, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/sharpen_3x3_saturating.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sharpen_3x3_saturating
// 3x3 sharpen (nine times centre minus eight neighbours, clamped to 0..255)
// over a raster-order RGB stream, with frame-edge pixels passed through.
// ----------------------------------------------------------------------------
// usage
//   i_pix  : pixels in raster order, one request per pixel
//   o_res  : results with column, row and last_of_run on the last result of
//            each input pixel; row r-1 comes out while row r goes in, the
//            last row comes out as it arrives, row 0 gives no result
//   i_cfg  : line_width (index 0) and frame_height (index 1), always ready;
//            write only while no pixel is in flight
// timing
//   a result passes the stage register r_b and then the output register r_o before it shows on o_res
//   one pixel per cycle while o_res is ready; a pixel with two results (row
//   ends, last row past column 0) or three (last row, last column) holds
//   input, as the single output register moves one result per cycle
//   the line stores are read at accept and written back when the pixel
//   leaves the second stage, one read and one write of its entry per pixel
// reset
//   counters, window and valid flags clear; registers go to 480 x 360
// stall
//   a held output keeps its value; the next pixel is still taken while the
//   output register waits, then input stalls until the results drain
// ----------------------------------------------------------------------------
module sharpen_3x3_saturating import shp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    shp_cfg_if.sink        i_cfg,
    shp_pix_in_if.sink     i_pix,
    shp_pix_out_if.source  o_res
);

    logic [LW_W-1:0] r_line_width;
    logic [FH_W-1:0] r_frame_height;
    t_col            r_col;
    t_row            r_row;
    t_pix            r_win [6];

    logic            r_b_valid;
    t_stage          r_b;
    logic [2:0]      r_pend;

    logic            r_o_valid;
    t_result         r_o;

    logic [WD_W-1:0] wd;
    t_col            wd_last;
    t_row            ht_last;
    t_col            c_sat;
    t_row            r_sat;
    t_col            n_col;
    t_row            n_row;
    t_stage          n_b;
    t_pix            in_px;
    logic            in_acc;
    logic            slot_free;
    logic            one_left;
    logic            load_out;
    logic            b_done;
    logic [2:0]      low_bit;
    t_pix            top;
    t_pix            mid;
    logic [8:0][PIX_W-1:0] w;
    t_pix            sel_px;
    t_col            sel_col;
    t_row            sel_row;
    t_result         n_o;

    // register write port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_W'(LW_RESET);
            r_frame_height <= FH_W'(FH_RESET);
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_LINE_WIDTH: begin
                    r_line_width <= i_cfg.wr_data[LW_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg.wr_data[FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective geometry
    always_comb begin
        if (r_line_width < LW_W'(MIN_DIM)) begin
            wd = WD_W'(MIN_DIM);
        end else if (WD_W'(r_line_width) > WD_W'(MAX_LINE_WIDTH)) begin
            wd = WD_W'(MAX_LINE_WIDTH);
        end else begin
            wd = WD_W'(r_line_width);
        end
        wd_last = COL_W'(wd - WD_W'(1));
        if (r_frame_height < FH_W'(MIN_DIM)) begin
            ht_last = ROW_W'(MIN_DIM - 1);
        end else begin
            ht_last = ROW_W'(r_frame_height - FH_W'(1));
        end
        c_sat = (r_col > wd_last) ? wd_last : r_col;
        r_sat = (r_row > ht_last) ? ht_last : r_row;
    end

    // input side: position tracking and stage load
    assign in_px       = {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
    assign i_pix.ready = !r_b_valid || b_done;
    assign in_acc      = i_pix.valid && i_pix.ready;

    always_comb begin
        if (c_sat == wd_last) begin
            n_col = '0;
            n_row = (r_sat == ht_last) ? '0 : r_sat + ROW_W'(1);
        end else begin
            n_col = c_sat + COL_W'(1);
            n_row = r_sat;
        end
        n_b.px      = in_px;
        n_b.col     = c_sat;
        n_b.row     = r_sat;
        n_b.edge_px = (r_sat == ROW_W'(1)) || (c_sat == COL_W'(1));
        n_b.emit[0] = (r_sat != '0) && (c_sat != '0);
        n_b.emit[1] = (r_sat != '0) && (c_sat == wd_last);
        n_b.emit[2] = (r_sat == ht_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores: read at accept, write back when the pixel retires;
    // consecutive pixels always hit different entries
    shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (b_done),
        .i_waddr (r_b.col),
        .i_wdata (mid),
        .i_re    (in_acc),
        .i_raddr (c_sat),
        .o_rdata (top)
    );

    shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (b_done),
        .i_waddr (r_b.col),
        .i_wdata (r_b.px),
        .i_re    (in_acc),
        .i_raddr (c_sat),
        .o_rdata (mid)
    );

    // second stage: window, kernel and result sequencing
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w[i] = r_win[i];
        end
        w[6] = top;
        w[7] = mid;
        w[8] = r_b.px;
    end

    assign slot_free = !r_o_valid || o_res.ready;
    assign low_bit   = r_pend & (~r_pend + 3'd1);
    assign one_left  = (r_pend & (r_pend - 3'd1)) == 3'd0;
    assign load_out  = r_b_valid && (r_pend != 3'd0) && slot_free;
    assign b_done    = r_b_valid && ((r_pend == 3'd0) || (slot_free && one_left));

    always_comb begin
        if (r_pend[0]) begin
            sel_px  = r_b.edge_px ? r_win[4] : sharpen(w);
            sel_col = r_b.col - COL_W'(1);
            sel_row = r_b.row - ROW_W'(1);
        end else if (r_pend[1]) begin
            sel_px  = mid;
            sel_col = r_b.col;
            sel_row = r_b.row - ROW_W'(1);
        end else begin
            sel_px  = r_b.px;
            sel_col = r_b.col;
            sel_row = r_b.row;
        end
        n_o.out_red      = sel_px[2*CH_W +: CH_W];
        n_o.out_green    = sel_px[CH_W +: CH_W];
        n_o.out_blue     = sel_px[0 +: CH_W];
        n_o.pixel_column = PXCOL_W'(sel_col);
        n_o.pixel_row    = sel_row;
        n_o.last_of_run  = one_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_pend    <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_b_valid <= 1'b1;
                r_pend    <= n_b.emit;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
                r_pend    <= '0;
            end else if (load_out) begin
                r_pend <= r_pend & ~low_bit;
            end
            if (b_done) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_b.px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b <= n_b;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (slot_free) begin
            r_o_valid <= load_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o <= n_o;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.out_red      = r_o.out_red;
    assign o_res.out_green    = r_o.out_green;
    assign o_res.out_blue     = r_o.out_blue;
    assign o_res.pixel_column = r_o.pixel_column;
    assign o_res.pixel_row    = r_o.pixel_row;
    assign o_res.last_of_run  = r_o.last_of_run;

endmodule
`default_nettype wire

FILE: rtl/shp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module shp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/shp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shp_checker
// Port-level checks for the sharpen filter, attached by bind.
// ----------------------------------------------------------------------------
module shp_checker import shp_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_cfg_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [CH_W-1:0]    i_out_red,
    input wire logic [CH_W-1:0]    i_out_green,
    input wire logic [CH_W-1:0]    i_out_blue,
    input wire logic [PXCOL_W-1:0] i_pixel_column,
    input wire logic [ROW_W-1:0]   i_pixel_row,
    input wire logic               i_last_of_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_red)
            && $stable(i_out_green) && $stable(i_out_blue)
            && $stable(i_pixel_column) && $stable(i_pixel_row)
            && $stable(i_last_of_run)))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // input only stalls while results are draining
    a_stall_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |=> i_out_valid)
        else $error("input stalled with nothing to deliver");

    // register port never blocks
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register port not ready");

endmodule

bind sharpen_3x3_saturating shp_checker u_shp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_pix.ready),
    .i_cfg_ready    (i_cfg.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_red      (o_res.out_red),
    .i_out_green    (o_res.out_green),
    .i_out_blue     (o_res.out_blue),
    .i_pixel_column (o_res.pixel_column),
    .i_pixel_row    (o_res.pixel_row),
    .i_last_of_run  (o_res.last_of_run)
);
`default_nettype wire
